### rtl/core/ufr_pkg.sv
// Shared types and constants for the upgrade frame receiver.
`timescale 1ns / 1ps

package ufr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h5a;
    localparam logic [7:0] MIN_LEN   = 8'd3;

    typedef enum logic [2:0] {
        PH_SYNC1 = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_CMD   = 3'd3,
        PH_BODY  = 3'd4
    } phase_t;

    typedef enum logic [0:0] {
        REG_ACK_CODE     = 1'b0,
        REG_VERSION_CODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] major_ver;
        logic [7:0] minor_ver;
        logic [7:0] build_ver;
        logic       is_version;
    } result_t;

endpackage

### rtl/core/ufr_in_stage.sv
// Input register stage: holds one received byte until the parser takes it.
`timescale 1ns / 1ps

module ufr_in_stage
    import ufr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic       pop,
    output logic       byte_valid,
    output logic [7:0] rx_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_axis_tready = !valid_reg || pop;
    assign valid_next    = s_axis_tvalid ? 1'b1 : (valid_reg && !pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            data_reg <= s_axis_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = data_reg;

endmodule

### rtl/core/ufr_parser.sv
// Frame parser: sync hunt, length, command, payload capture and checksum check.
`timescale 1ns / 1ps

module ufr_parser
    import ufr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic [7:0] ack_code,
    input  logic [7:0] version_code,
    output logic       res_valid,
    output result_t    res
);

    phase_t     phase_reg,     phase_next;
    logic [7:0] left_reg,      left_next;
    logic [7:0] sum_reg,       sum_next;
    logic [7:0] cmd_reg,       cmd_next;
    logic [1:0] pidx_reg,      pidx_next;
    logic [7:0] pay_reg [3];
    logic [7:0] pay_next [3];
    logic       is_check;
    logic       cmd_ack;
    logic       cmd_ver;

    assign is_check = (left_reg <= 8'd1);
    assign cmd_ack  = (cmd_reg == ack_code);
    assign cmd_ver  = (cmd_reg == version_code);

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (step) begin
            unique case (phase_reg)
                PH_SYNC2: phase_next = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
                PH_LEN:   phase_next = (rx_byte < MIN_LEN) ? PH_SYNC1 : PH_CMD;
                PH_CMD:   phase_next = PH_BODY;
                PH_BODY:  phase_next = is_check ? PH_SYNC1 : PH_BODY;
                default:  phase_next = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        left_next = left_reg;
        sum_next  = sum_reg;
        cmd_next  = cmd_reg;
        pidx_next = pidx_reg;
        pay_next  = pay_reg;
        res_valid = 1'b0;
        res       = '0;
        if (step) begin
            unique case (phase_reg)
                PH_LEN: begin
                    if (rx_byte >= MIN_LEN) begin
                        sum_next  = rx_byte;
                        left_next = rx_byte - 8'd1;
                        pidx_next = 2'd0;
                        pay_next  = '{8'd0, 8'd0, 8'd0};
                    end
                end
                PH_CMD: begin
                    cmd_next  = rx_byte;
                    sum_next  = sum_reg + rx_byte;
                    left_next = left_reg - 8'd1;
                end
                PH_BODY: begin
                    if (!is_check) begin
                        if (pidx_reg != 2'd3) begin
                            pay_next[pidx_reg] = rx_byte;
                            pidx_next          = pidx_reg + 2'd1;
                        end
                        sum_next  = sum_reg + rx_byte;
                        left_next = left_reg - 8'd1;
                    end else begin
                        left_next = 8'd0;
                        if (rx_byte == sum_reg && (cmd_ack || cmd_ver)) begin
                            res_valid = 1'b1;
                            if (!cmd_ack) begin
                                res.is_version = 1'b1;
                                res.build_ver  = pay_reg[0];
                                res.minor_ver  = pay_reg[1];
                                res.major_ver  = pay_reg[2];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            left_reg  <= 8'd0;
            sum_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            pidx_reg  <= 2'd0;
            pay_reg   <= '{8'd0, 8'd0, 8'd0};
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
            pidx_reg  <= pidx_next;
            pay_reg   <= pay_next;
        end
    end

endmodule

### rtl/core/ufr_out_stage.sv
// Result register stage driving the master stream port.
`timescale 1ns / 1ps

module ufr_out_stage
    import ufr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  result_t     res,
    output logic        can_take,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [7:0] build_ver, [15:8] minor_ver, [23:16] major_ver
    output logic [0:0]  m_axis_tuser   // [0] is_version
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_take   = !valid_reg || m_axis_tready;
    assign valid_next = can_take ? push : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_take && push) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = {res_reg.major_ver, res_reg.minor_ver, res_reg.build_ver};
    assign m_axis_tuser[0] = res_reg.is_version;

endmodule

### rtl/core/upgrade_frame_receiver.sv
// Top level of the upgrade frame receiver.
`timescale 1ns / 1ps

// Byte-stream deframer: hunts for two 0x5a sync bytes, takes a length byte L
// (L below 3 is dropped), then a command byte, L-3 payload bytes and a checksum
// equal to the 8-bit sum of length, command and payload. A frame with a good
// checksum whose command matches ack_code (register 0) or version_code
// (register 1) yields one result word; version results carry the first three
// payload bytes, missing bytes as zero. One byte is accepted per clock while
// the output is not stalled; a byte passes the input register and the parser,
// and its result, if any, leaves from the output register. Ready on the input
// follows the output register's ready combinationally.

module upgrade_frame_receiver
    import ufr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] build_ver, [15:8] minor_ver, [23:16] major_ver
    output logic [0:0]  m_axis_tuser,   // [0] is_version
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    logic [7:0] ack_reg;
    logic [7:0] ver_reg;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       can_take;
    logic       step;
    logic       res_valid;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_reg <= 8'd0;
            ver_reg <= 8'd1;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_ACK_CODE:     ack_reg <= cfg_wdata;
                REG_VERSION_CODE: ver_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign step = byte_valid && can_take;

    ufr_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pop           (step),
        .byte_valid    (byte_valid),
        .rx_byte       (rx_byte)
    );

    ufr_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .rx_byte      (rx_byte),
        .ack_code     (ack_reg),
        .version_code (ver_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    ufr_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (res_valid),
        .res           (res),
        .can_take      (can_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### rtl/core/ufr_checker.sv
// Port-level checks for the upgrade frame receiver, bound to the top level.
`timescale 1ns / 1ps

module ufr_checker
    import ufr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_ack_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
        else $error("acknowledge word carries version bytes");

    // input only stalls behind a waiting result word
    a_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no result word waiting");

endmodule

bind upgrade_frame_receiver ufr_checker u_ufr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
